// ===== rtl/kes_pkg.sv =====
package kes_pkg;

    localparam int ANGLE_WIDTH_DEF = 32;
    localparam int ECC_W           = 16;
    localparam int TOL_W           = 16;
    localparam int ITER_W          = 8;
    localparam int CFG_INDEX_W     = 8;

    localparam logic [TOL_W-1:0]  TOL_RESET   = 16'd4;
    localparam logic [ITER_W-1:0] LIMIT_RESET = 8'd100;

    localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ITER_LIMIT  = 8'd1;

    // 2*pi in Q60, gain 1/K as a decimal fraction over 1e18
    localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
    localparam logic [63:0] GAIN_E18   = 64'd607252935008881256;
    localparam logic [63:0] TEN_E18    = 64'd1000000000000000000;

    localparam int ATAN_DEPTH = 64;
    typedef logic [63:0] t_atan_arr [ATAN_DEPTH];

    function automatic logic [63:0] two_pi_q(input int frac);
        return (TWO_PI_Q60 + (64'd1 << (59 - frac))) >> (60 - frac);
    endfunction

    function automatic logic [63:0] pi_q(input int frac);
        return (TWO_PI_Q60 + (64'd1 << (60 - frac))) >> (61 - frac);
    endfunction

    function automatic logic [63:0] half_pi_q(input int frac);
        return (TWO_PI_Q60 + (64'd1 << (61 - frac))) >> (62 - frac);
    endfunction

    function automatic logic [63:0] round_q62(input logic [63:0] v, input int frac);
        return (v + (64'd1 << (61 - frac))) >> (62 - frac);
    endfunction

    // arctan(2^-i) from its power series, evaluated at elaboration
    function automatic t_atan_arr atan_table(input int frac);
        t_atan_arr   tab;
        logic [63:0] sum;
        logic [63:0] term;
        int          sh;
        for (int i = 0; i < ATAN_DEPTH; i++) begin
            tab[i] = 64'd0;
        end
        tab[0] = round_q62(TWO_PI_Q60 >> 1, frac);
        for (int i = 1; i < frac; i++) begin
            sum = 64'd0;
            for (int k = 0; k < 64; k++) begin
                sh = i * (2 * k + 1);
                if (sh >= 62) break;
                term = (64'd1 << (62 - sh)) / 64'(2 * k + 1);
                if (k % 2 == 1) sum = sum - term;
                else            sum = sum + term;
            end
            tab[i] = round_q62(sum, frac);
        end
        return tab;
    endfunction

    function automatic logic [63:0] gain_q(input int frac);
        logic [63:0] num;
        logic [63:0] q;
        num = GAIN_E18;
        q   = 64'd0;
        for (int k = 0; k < frac + 1; k++) begin
            num = num << 1;
            q   = q << 1;
            if (num >= TEN_E18) begin
                num = num - TEN_E18;
                q   = q | 64'd1;
            end
        end
        return (q + 64'd1) >> 1;
    endfunction

endpackage

// ===== rtl/kepler_equation_solver.sv =====
// Kepler equation solver: returns the eccentric anomaly E (Q3.F, reduced into
// [0, 2*pi)) for a mean anomaly M (signed Q4.F, F = ANGLE_WIDTH-4) and an
// eccentricity (Q0.16) by Newton-Raphson on E - e*sin(E) - M, plus a status
// bit (limit reached) and the iteration count. One item is worked at a time;
// the input is ready only while the sequencer is idle. Each Newton iteration
// runs F CORDIC micro-rotations, ANGLE_WIDTH restoring division steps
// (skipped when the quotient saturates), angle reduction, the two products
// and the update; an item repeats these steps for each iteration it uses.
// A finished result waits in the output register while the next item is
// accepted.
module kepler_equation_solver
    import kes_pkg::*;
#(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [TOL_W-1:0]       i_cfg_data,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: mean_anomaly [ANGLE_WIDTH], eccentricity [16], zero fill
    input  logic [((ANGLE_WIDTH+ECC_W+7)/8)*8-1:0] s_axis_tdata,
    // output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata: eccentric_anomaly [ANGLE_WIDTH-1], status [1], iterations_used [8], zero fill
    output logic [((ANGLE_WIDTH+ITER_W+7)/8)*8-1:0] m_axis_tdata
);

    localparam int FRAC  = ANGLE_WIDTH - 4;
    localparam int XW    = ANGLE_WIDTH + 2;
    localparam int PW    = XW + ECC_W + 1;
    localparam int QW    = ANGLE_WIDTH;
    localparam int JW    = $clog2(FRAC);
    localparam int CW    = $clog2(QW);
    localparam int OUT_W = ((ANGLE_WIDTH + ITER_W + 7) / 8) * 8;

    localparam logic signed [XW-1:0] TWO_PI  = XW'(two_pi_q(FRAC));
    localparam logic signed [XW-1:0] PI      = XW'(pi_q(FRAC));
    localparam logic signed [XW-1:0] HALF_PI = XW'(half_pi_q(FRAC));
    localparam logic signed [XW-1:0] GAIN    = XW'(gain_q(FRAC));
    localparam logic signed [XW-1:0] ONE     = XW'(64'd1 << FRAC);
    localparam logic signed [XW-1:0] E_MAX   = XW'((64'd1 << (FRAC + 3)) - 64'd1);
    localparam logic signed [XW-1:0] E_MIN   = -E_MAX - XW'(1);
    localparam t_atan_arr            ATAN    = atan_table(FRAC);
    localparam logic [QW-1:0]        Q_CAP   = {QW{1'b1}};
    localparam logic [18:0]          ECC_SWITCH = 19'd262144;

    typedef enum logic [3:0] {
        S_IDLE, S_WRAP, S_START, S_FOLD1, S_FOLD2, S_CORDIC, S_MULS, S_MULC,
        S_DEN, S_DCHK, S_DIV, S_UPD, S_OUT
    } t_state;

    t_state                  r_state, r_wret;
    logic signed [XW-1:0]    r_m, r_e, r_w, r_x, r_y, r_z, r_f;
    logic [XW-1:0]           r_fmag, r_d, r_r;
    logic [3:0]              r_sh;
    logic [QW-1:0]           r_q;
    logic [CW-1:0]           r_cnt;
    logic [ECC_W-1:0]        r_ecc;
    logic                    r_neg;
    logic [JW-1:0]           r_j;
    logic signed [PW-1:0]    r_p;
    logic [ITER_W-1:0]       r_iters;
    logic                    r_status;
    logic [TOL_W-1:0]        r_tol;
    logic [ITER_W-1:0]       r_lim;
    logic                    r_o_valid;
    logic [ANGLE_WIDTH-2:0]  r_o_ea;
    logic                    r_o_stat;
    logic [ITER_W-1:0]       r_o_iters;

    logic signed [ECC_W:0]   ecc_s;
    logic signed [XW-1:0]    mul_b, sin_v, cos_v;
    logic signed [PW-1:0]    prod;
    logic signed [XW-1:0]    atan_j, y_sh, x_sh;
    logic signed [XW-1:0]    den_v, step_v, e_new, e_sat;
    logic [XW:0]             rem_try;
    logic [ITER_W-1:0]       lim_eff, iters_nx;
    logic [18:0]             ecc_x5;
    logic                    out_load;

    assign ecc_s  = signed'({1'b0, r_ecc});
    assign sin_v  = r_neg ? -r_y : r_y;
    assign cos_v  = r_neg ? -r_x : r_x;
    assign mul_b  = (r_state == S_MULS) ? sin_v : cos_v;
    assign prod   = ecc_s * mul_b;

    assign atan_j = signed'(XW'(ATAN[6'(r_j)]));
    assign y_sh   = r_y >>> r_j;
    assign x_sh   = r_x >>> r_j;

    assign den_v   = ONE - signed'(r_p[XW+15:16]);
    assign rem_try = {r_r, r_sh[3]};
    assign step_v  = r_f[XW-1] ? -signed'(XW'(r_q)) : signed'(XW'(r_q));
    assign e_new   = r_e - step_v;
    assign e_sat   = (e_new > E_MAX) ? E_MAX : ((e_new < E_MIN) ? E_MIN : e_new);
    assign lim_eff = (r_lim == '0) ? ITER_W'(1) : r_lim;
    assign iters_nx = r_iters + ITER_W'(1);
    assign ecc_x5  = {1'b0, r_ecc, 2'b00} + 19'(r_ecc);
    assign out_load = (r_state == S_OUT) && (!r_o_valid || m_axis_tready);

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = OUT_W'({r_o_iters, r_o_stat, r_o_ea});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wret    <= S_IDLE;
            r_tol     <= TOL_RESET;
            r_lim     <= LIMIT_RESET;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_TOLERANCE)       r_tol <= i_cfg_data;
                else if (i_cfg_index == REG_ITER_LIMIT) r_lim <= i_cfg_data[ITER_W-1:0];
            end
            if (out_load)           r_o_valid <= 1'b1;
            else if (m_axis_tready) r_o_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_w     <= XW'(signed'(s_axis_tdata[ANGLE_WIDTH-1:0]));
                        r_ecc   <= s_axis_tdata[ANGLE_WIDTH +: ECC_W];
                        r_iters <= '0;
                        r_wret  <= S_START;
                        r_state <= S_WRAP;
                    end
                end
                // reduce r_w into [0, 2*pi), one add per cycle
                S_WRAP: begin
                    if (r_w < 0)            r_w <= r_w + TWO_PI;
                    else if (r_w >= TWO_PI) r_w <= r_w - TWO_PI;
                    else                    r_state <= r_wret;
                end
                S_START: begin
                    r_m <= r_w;
                    if (ecc_x5 < ECC_SWITCH) begin
                        r_e <= r_w;
                    end else begin
                        r_e <= PI;
                        r_w <= PI;
                    end
                    r_state <= S_FOLD1;
                end
                S_FOLD1: begin
                    if (r_w > PI) r_w <= r_w - TWO_PI;
                    r_state <= S_FOLD2;
                end
                S_FOLD2: begin
                    if (r_w > HALF_PI) begin
                        r_z   <= r_w - PI;
                        r_neg <= 1'b1;
                    end else if (r_w < -HALF_PI) begin
                        r_z   <= r_w + PI;
                        r_neg <= 1'b1;
                    end else begin
                        r_z   <= r_w;
                        r_neg <= 1'b0;
                    end
                    r_x     <= GAIN;
                    r_y     <= '0;
                    r_j     <= '0;
                    r_state <= S_CORDIC;
                end
                S_CORDIC: begin
                    if (!r_z[XW-1]) begin
                        r_x <= r_x - y_sh;
                        r_y <= r_y + x_sh;
                        r_z <= r_z - atan_j;
                    end else begin
                        r_x <= r_x + y_sh;
                        r_y <= r_y - x_sh;
                        r_z <= r_z + atan_j;
                    end
                    r_j <= r_j + JW'(1);
                    if (r_j == JW'(FRAC - 1)) r_state <= S_MULS;
                end
                S_MULS: begin
                    r_p     <= prod;
                    r_state <= S_MULC;
                end
                S_MULC: begin
                    r_f     <= r_e - signed'(r_p[XW+15:16]) - r_m;
                    r_p     <= prod;
                    r_state <= S_DEN;
                end
                S_DEN: begin
                    r_d     <= (den_v < XW'(1)) ? XW'(1) : den_v;
                    r_fmag  <= r_f[XW-1] ? -r_f : r_f;
                    r_state <= S_DCHK;
                end
                S_DCHK: begin
                    if ({4'b0000, r_fmag} >= {r_d, 4'b0000}) begin
                        r_q     <= Q_CAP;
                        r_state <= S_UPD;
                    end else begin
                        r_r     <= r_fmag >> 4;
                        r_sh    <= r_fmag[3:0];
                        r_q     <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                // restoring division, one quotient bit per cycle
                S_DIV: begin
                    if (rem_try >= {1'b0, r_d}) begin
                        r_r <= XW'(rem_try - {1'b0, r_d});
                        r_q <= {r_q[QW-2:0], 1'b1};
                    end else begin
                        r_r <= rem_try[XW-1:0];
                        r_q <= {r_q[QW-2:0], 1'b0};
                    end
                    r_sh  <= {r_sh[2:0], 1'b0};
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(QW - 1)) r_state <= S_UPD;
                end
                S_UPD: begin
                    r_e     <= e_sat;
                    r_w     <= e_sat;
                    r_iters <= iters_nx;
                    r_state <= S_WRAP;
                    if (iters_nx == lim_eff) begin
                        r_status <= 1'b1;
                        r_wret   <= S_OUT;
                    end else if (r_fmag <= XW'(r_tol)) begin
                        r_status <= 1'b0;
                        r_wret   <= S_OUT;
                    end else begin
                        r_wret   <= S_FOLD1;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_o_ea    <= r_w[ANGLE_WIDTH-2:0];
                        r_o_stat  <= r_status;
                        r_o_iters <= r_iters;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== tb/sv/tb_kepler_equation_solver.sv =====
module tb_kepler_equation_solver
    import kes_pkg::*;
;

    localparam int AW  = 32;
    localparam int FR  = AW - 4;
    localparam int SDW = ((AW + ECC_W + 7) / 8) * 8;
    localparam int MDW = ((AW + ITER_W + 7) / 8) * 8;

    localparam logic [63:0] TWO_PI_Q60_C = 64'h6487ED5110B4611A;
    localparam logic [63:0] GAIN_NUM     = 64'd607252935008881256;
    localparam logic [63:0] GAIN_DEN     = 64'd1000000000000000000;

    // first member sits in the top bits
    typedef struct packed {
        logic [ITER_W-1:0] iters;
        logic              limit_hit;
        logic [AW-2:0]     anom;
    } anom_res_t;

    typedef struct {
        logic [AW-1:0]    mean;
        logic [ECC_W-1:0] ecc;
        bit               typed;
        anom_res_t        want;
    } orbit_row_t;

    typedef struct {
        logic [TOL_W-1:0]  tol;
        logic [ITER_W-1:0] lim;
        int                count;
    } solve_phase_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [TOL_W-1:0]       i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // tdata: mean_anomaly [31:0], eccentricity [47:32]
    logic [SDW-1:0]         s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // tdata: eccentric_anomaly [30:0], status [31], iterations_used [39:32]
    logic [MDW-1:0]         m_axis_tdata;

    kepler_equation_solver #(.ANGLE_WIDTH(AW)) i_dut (.*);

    longint    two_pi_c, pi_c, half_pi_c, gain_c;
    longint    atan_c [FR];
    int        tol_now, lim_now;
    int        idle_mode;
    int        mismatches;
    int        items_sent;
    int        results_seen;
    anom_res_t pending_anoms [$];

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint rnd_q62(logic [63:0] v);
        return longint'((v + (64'd1 << (61 - FR))) >> (62 - FR));
    endfunction

    function automatic void build_consts();
        logic [63:0] sum, term, num, q;
        int          sh;
        two_pi_c  = longint'((TWO_PI_Q60_C + (64'd1 << (59 - FR))) >> (60 - FR));
        pi_c      = longint'((TWO_PI_Q60_C + (64'd1 << (60 - FR))) >> (61 - FR));
        half_pi_c = longint'((TWO_PI_Q60_C + (64'd1 << (61 - FR))) >> (62 - FR));
        atan_c[0] = rnd_q62(TWO_PI_Q60_C >> 1);
        for (int i = 1; i < FR; i++) begin
            sum = 64'd0;
            for (int k = 0; k < 64; k++) begin
                sh = i * (2 * k + 1);
                if (sh >= 62) break;
                term = (64'd1 << (62 - sh)) / 64'(2 * k + 1);
                if (k % 2 == 1) sum = sum - term;
                else            sum = sum + term;
            end
            atan_c[i] = rnd_q62(sum);
        end
        num = GAIN_NUM;
        q   = 64'd0;
        for (int k = 0; k < FR + 1; k++) begin
            num = num << 1;
            q   = q << 1;
            if (num >= GAIN_DEN) begin
                num = num - GAIN_DEN;
                q   = q | 64'd1;
            end
        end
        gain_c = longint'((q + 64'd1) >> 1);
    endfunction

    function automatic longint wrap_angle(longint v);
        while (v < 0) v += two_pi_c;
        while (v >= two_pi_c) v -= two_pi_c;
        return v;
    endfunction

    function automatic void cordic_sc(longint a, output longint s, output longint c);
        longint x, y, z, t;
        bit     flip;
        x    = gain_c;
        y    = 0;
        flip = 1'b0;
        z    = wrap_angle(a);
        if (z > pi_c) z -= two_pi_c;
        if (z > half_pi_c) begin
            z -= pi_c;
            flip = 1'b1;
        end else if (z < -half_pi_c) begin
            z += pi_c;
            flip = 1'b1;
        end
        for (int j = 0; j < FR; j++) begin
            if (z >= 0) begin
                t = x - (y >>> j);
                y = y + (x >>> j);
                x = t;
                z -= atan_c[j];
            end else begin
                t = x + (y >>> j);
                y = y - (x >>> j);
                x = t;
                z += atan_c[j];
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint newton_quot(longint f, longint d);
        logic [63:0] mag, den, q, r;
        mag = (f < 0) ? 64'(-f) : 64'(f);
        den = 64'(d);
        q   = mag / den;
        r   = mag % den;
        if (q >= 64'd16) begin
            q = (64'd1 << (FR + 4)) - 64'd1;
        end else begin
            for (int k = 0; k < FR; k++) begin
                r = r << 1;
                q = q << 1;
                if (r >= den) begin
                    r = r - den;
                    q = q | 64'd1;
                end
            end
        end
        return (f < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic anom_res_t solve_kepler(logic [AW-1:0] mean, logic [ECC_W-1:0] ecc_in);
        longint    m, e_an, f, d, s, c, ecc, e_max, fmag;
        int        lim, iters;
        anom_res_t res;
        e_max = (longint'(1) << (FR + 3)) - 1;
        lim   = (lim_now == 0) ? 1 : lim_now;
        iters = 0;
        res.limit_hit = 1'b0;
        m    = wrap_angle(longint'($signed(mean)));
        ecc  = longint'(ecc_in);
        e_an = (ecc * 5 < 262144) ? m : pi_c;
        forever begin
            cordic_sc(e_an, s, c);
            f = e_an - ((ecc * s) >>> 16) - m;
            d = (longint'(1) << FR) - ((ecc * c) >>> 16);
            if (d < 1) d = 1;
            e_an -= newton_quot(f, d);
            if (e_an > e_max) e_an = e_max;
            if (e_an < -e_max - 1) e_an = -e_max - 1;
            iters++;
            if (iters == lim) begin
                res.limit_hit = 1'b1;
                break;
            end
            fmag = (f < 0) ? -f : f;
            if (fmag <= tol_now) break;
        end
        res.anom  = (AW-1)'(wrap_angle(e_an));
        res.iters = ITER_W'(iters);
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
        mismatches++;
    endtask

    // compare each result transaction against the oldest expectation
    always @(posedge i_clk) begin
        anom_res_t got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[AW+ITER_W-1:0];
            if (pending_anoms.size() == 0) begin
                report_mismatch("unexpected result, anomaly", got.anom, -1);
            end else begin
                want = pending_anoms.pop_front();
                if (got.anom !== want.anom)
                    report_mismatch("eccentric_anomaly", got.anom, want.anom);
                if (got.limit_hit !== want.limit_hit)
                    report_mismatch("status", got.limit_hit, want.limit_hit);
                if (got.iters !== want.iters)
                    report_mismatch("iterations_used", got.iters, want.iters);
            end
            results_seen++;
        end
    end

    always @(negedge i_clk) begin
        case (idle_mode)
            0:       m_axis_tready <= ($urandom_range(0, 99) >= 74);
            1:       m_axis_tready <= ($urandom_range(0, 99) >= 22);
            default: m_axis_tready <= 1'b1;
        endcase
    end

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [TOL_W-1:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_TOLERANCE)       tol_now = int'(val);
        else if (idx == REG_ITER_LIMIT) lim_now = int'(val[ITER_W-1:0]);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain_results();
        wait (pending_anoms.size() == 0);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic send_orbit(logic [AW-1:0] mean, logic [ECC_W-1:0] ecc,
                              bit typed, anom_res_t want);
        int gap_pct;
        gap_pct = (idle_mode == 0) ? 22 : (idle_mode == 1) ? 74 : 0;
        while ($urandom_range(0, 99) < gap_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = '0;
        s_axis_tdata[AW-1:0]       = mean;
        s_axis_tdata[AW+ECC_W-1:AW] = ecc;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_anoms.push_back(typed ? want : solve_kepler(mean, ecc));
        items_sent++;
        if (items_sent >= 340)      idle_mode = 2;
        else if (items_sent >= 170) idle_mode = 1;
        @(negedge i_clk);
    endtask

    initial begin
        orbit_row_t   rows [$];
        solve_phase_t phases [$];
        logic [AW-1:0]    mean;
        logic [ECC_W-1:0] ecc;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        idle_mode     = 0;
        mismatches    = 0;
        items_sent    = 0;
        results_seen  = 0;
        tol_now       = int'(TOL_RESET);
        lim_now       = int'(LIMIT_RESET);
        build_consts();

        // zero eccentricity converges in one step at E = M; the list also holds nonzero eccentricities
        rows = '{
            '{32'h0000_0000, 16'h0000, 1'b1, '{8'd1, 1'b0, 31'h0000_0000}},
            '{32'h1000_0000, 16'h0000, 1'b1, '{8'd1, 1'b0, 31'h1000_0000}},
            '{32'h8000_0000, 16'h0000, 1'b0, '0},
            '{32'h7FFF_FFFF, 16'h0000, 1'b0, '0},
            '{32'h8000_0000, 16'hFFFF, 1'b0, '0},
            '{32'h7FFF_FFFF, 16'hFFFF, 1'b0, '0},
            '{32'hFFFF_FFFF, 16'h4000, 1'b0, '0},
            '{32'h6487_ED51, 16'h8000, 1'b0, '0},
            '{32'h9B78_12AF, 16'h8000, 1'b0, '0},
            '{32'h3243_F6A9, 16'hCCCC, 1'b0, '0},
            '{32'h3243_F6A9, 16'hCCCD, 1'b0, '0},
            '{32'h0000_0001, 16'hFFFF, 1'b0, '0},
            '{32'h1921_FB54, 16'hF000, 1'b0, '0},
            '{32'h4B65_F1FD, 16'h0001, 1'b0, '0},
            '{32'hE000_0000, 16'hAAAA, 1'b0, '0},
            '{32'h5555_5555, 16'h5555, 1'b0, '0}
        };
        phases = '{
            '{16'd0,     8'd255, 15},
            '{16'hFFFF,  8'd1,   100},
            '{16'd4,     8'd0,   40},
            '{16'd4,     8'd100, 130},
            '{16'd200,   8'd8,   120},
            '{16'd0,     8'd6,   95}
        };

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i]) send_orbit(rows[i].mean, rows[i].ecc, rows[i].typed, rows[i].want);
        s_axis_tvalid = 1'b0;

        foreach (phases[p]) begin
            drain_results();
            write_reg(REG_TOLERANCE, phases[p].tol);
            write_reg(REG_ITER_LIMIT, TOL_W'(phases[p].lim));
            // out-of-range index must leave both registers alone
            if (p == 2) write_reg(REG_ITER_LIMIT + 8'd1, 16'h0055);
            for (int n = 0; n < phases[p].count; n++) begin
                mean = ($urandom_range(0, 3) == 0) ? AW'($signed($urandom_range(0, 32'h3FFF_FFFF))
                                                     - 32'sh2000_0000) : AW'($urandom);
                case ($urandom_range(0, 3))
                    0:       ecc = ECC_W'($urandom);
                    1:       ecc = ECC_W'($urandom_range(0, 52428));
                    2:       ecc = ECC_W'($urandom_range(52429, 65535));
                    default: ecc = ECC_W'($urandom_range(0, 2000));
                endcase
                send_orbit(mean, ecc, 1'b0, '0);
            end
            s_axis_tvalid = 1'b0;
        end

        wait (pending_anoms.size() == 0);
        repeat (20) @(posedge i_clk);
        $display("covered %0d orbits and %0d results over %0d register settings",
                 items_sent, results_seen, phases.size() + 1);
        $display("with tolerance 0..65535, limits 0..255, e across the 0.8 start switch");
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #1_000_000_000;
        $display("timeout with %0d results outstanding", pending_anoms.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== kepler_equation_solver.f =====
rtl/kes_pkg.sv
rtl/kepler_equation_solver.sv
tb/sv/tb_kepler_equation_solver.sv
